// ===== src/linked_list_queue_manager_top_defines.svh =====
// Assertion macros for the linked-list queue manager.
// Used by linked_list_queue_manager_top; expects clk and rst_n in scope.
`ifndef LINKED_LIST_QUEUE_MANAGER_TOP_DEFINES_SVH
`define LINKED_LIST_QUEUE_MANAGER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LLQM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LLQM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/llqm_pkg.sv =====
// Package for the linked-list queue manager: pool size, pointer widths,
// command and status codes. No dependencies.
package llqm_pkg;

    // Pool size and derived widths
    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int PTR_W   = IDX_W + 1;
    localparam int ROOM_W  = PTR_W + 1;
    localparam int SPAN_W  = PTR_W + 5;

    // Stream widths
    localparam int IN_W  = 24;
    localparam int OUT_W = 24;

    typedef logic [PTR_W-1:0] ptr_t;

    // Null marker used in every link, head and tail
    localparam ptr_t PTR_NULL = PTR_W'(ENTRIES);

    typedef enum logic [2:0] {
        CMD_APPEND  = 3'd0,
        CMD_GROUP   = 3'd1,
        CMD_POP     = 3'd2,
        CMD_UNLINK  = 3'd3,
        CMD_PRESENT = 3'd4,
        CMD_PEEK    = 3'd5,
        CMD_AUDIT   = 3'd6,
        CMD_CLEAR   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_CORRUPT = 2'd3
    } status_t;

    // Any pointer at or above the pool size is null
    function automatic logic is_null(input ptr_t p);
        return (p >= PTR_NULL);
    endfunction

endpackage

// ===== src/linked_list_queue_manager_top.sv =====
// Linked-list queue manager: one singly linked FIFO over a pool of entries.
// Depends on llqm_pkg and linked_list_queue_manager_top_defines.svh.
//
//  Channel   Dir  Handshake                       Contents
//  s_axis    in   s_axis_tvalid / s_axis_tready   cmd, entry_id, group_count, group_stride
//  m_axis    out  m_axis_tvalid / m_axis_tready   status, entry_out, found, count
//
// One command at a time. Group append checks its bounds in S_GRP_CHK, then writes its
// links in S_GRP_LOOP; unlink, present and audit walk the list at one link per cycle
// through the link memory read port.
// A finished result sits in the output register; the next command may start
// while it waits, and only its own finish stalls on a full output register.
// Reset clears head, tail and length; the link memory is not cleared.
`include "linked_list_queue_manager_top_defines.svh"

module linked_list_queue_manager_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [2:0] cmd, [10:3] entry_id, [19:11] group_count, [23:20] group_stride
    input  logic [llqm_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [1:0] status, [9:2] entry_out, [10] found, [19:11] count, [23:20] zero
    output logic [llqm_pkg::OUT_W-1:0] m_axis_tdata
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_EXEC     = 12'b0000_0000_0010,
        S_APPEND2  = 12'b0000_0000_0100,
        S_GRP_CHK  = 12'b0000_0000_1000,
        S_GRP_LOOP = 12'b0000_0001_0000,
        S_POP      = 12'b0000_0010_0000,
        S_PEEK     = 12'b0000_0100_0000,
        S_WALK     = 12'b0000_1000_0000,
        S_UNLINK   = 12'b0001_0000_0000,
        S_UNL_FIX  = 12'b0010_0000_0000,
        S_DONE     = 12'b0100_0000_0000,
        S_SPARE    = 12'b1000_0000_0000
    } state_t;

    state_t                              state_reg, state_next;
    llqm_pkg::cmd_t                      cmd_reg, cmd_next;
    logic [llqm_pkg::IDX_W-1:0]          id_reg, id_next;
    llqm_pkg::ptr_t                      n_reg, n_next;
    logic [3:0]                          stride_reg, stride_next;
    llqm_pkg::ptr_t                      head_reg, head_next;
    llqm_pkg::ptr_t                      tail_reg, tail_next;
    llqm_pkg::ptr_t                      len_reg, len_next;
    llqm_pkg::ptr_t                      cur_reg, cur_next;
    llqm_pkg::ptr_t                      prev_reg, prev_next;
    llqm_pkg::ptr_t                      steps_reg, steps_next;
    logic                                first_reg, first_next;
    logic [llqm_pkg::SPAN_W-1:0]         prod_reg, prod_next;
    llqm_pkg::status_t                   res_status_reg, res_status_next;
    logic [llqm_pkg::IDX_W-1:0]          res_entry_reg, res_entry_next;
    logic                                res_found_reg, res_found_next;
    llqm_pkg::ptr_t                      res_count_reg, res_count_next;
    logic                                m_valid_reg, m_valid_next;
    logic [llqm_pkg::OUT_W-1:0]          m_data_reg, m_data_next;

    // Link memory ports
    logic                                mem_we;
    logic [llqm_pkg::IDX_W-1:0]          mem_waddr;
    llqm_pkg::ptr_t                      mem_wdata;
    logic [llqm_pkg::IDX_W-1:0]          mem_raddr;
    llqm_pkg::ptr_t                      rdata_reg;
    llqm_pkg::ptr_t                      link_mem [llqm_pkg::ENTRIES];

    // Shared checks
    logic                                ends_disagree;
    logic                                id_oop;
    llqm_pkg::ptr_t                      id_ptr;
    llqm_pkg::ptr_t                      walk_cur;
    logic [llqm_pkg::ROOM_W-1:0]         room;
    logic [llqm_pkg::SPAN_W-1:0]         span;
    llqm_pkg::ptr_t                      len_dec;
    llqm_pkg::ptr_t                      count_out;

    assign ends_disagree = llqm_pkg::is_null(head_reg) != llqm_pkg::is_null(tail_reg);
    assign id_ptr        = {1'b0, id_reg};
    assign id_oop        = llqm_pkg::is_null(id_ptr);
    assign walk_cur      = first_reg ? cur_reg : rdata_reg;
    assign room          = llqm_pkg::ROOM_W'(llqm_pkg::ENTRIES) - llqm_pkg::ROOM_W'(len_reg);
    assign span          = llqm_pkg::SPAN_W'(id_reg) + prod_reg;
    assign len_dec       = (len_reg == '0) ? '0 : len_reg - 1'b1;
    assign count_out     = (cmd_reg == llqm_pkg::CMD_AUDIT) ? res_count_reg : len_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Link memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= link_mem[mem_raddr];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        n_next          = n_reg;
        stride_next     = stride_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        len_next        = len_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        steps_next      = steps_reg;
        first_next      = first_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_found_next  = res_found_reg;
        res_count_next  = res_count_reg;
        m_valid_next    = m_valid_reg & ~m_axis_tready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = llqm_pkg::PTR_NULL;
        mem_raddr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next        = llqm_pkg::cmd_t'(s_axis_tdata[2:0]);
                    id_next         = s_axis_tdata[10:3];
                    n_next          = s_axis_tdata[19:11];
                    stride_next     = s_axis_tdata[23:20];
                    res_status_next = llqm_pkg::ST_OK;
                    res_entry_next  = '0;
                    res_found_next  = 1'b0;
                    res_count_next  = '0;
                    state_next      = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                case (cmd_reg)
                    llqm_pkg::CMD_APPEND:
                    begin
                        if (id_oop || len_reg >= llqm_pkg::PTR_NULL)
                        begin
                            res_status_next = llqm_pkg::ST_INVALID;
                        end
                        else if (ends_disagree)
                        begin
                            res_status_next = llqm_pkg::ST_CORRUPT;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = id_reg;
                            mem_wdata = llqm_pkg::PTR_NULL;
                            if (llqm_pkg::is_null(head_reg))
                            begin
                                head_next = id_ptr;
                                tail_next = id_ptr;
                                len_next  = len_reg + 1'b1;
                            end
                            else
                            begin
                                state_next = S_APPEND2;
                            end
                        end
                    end
                    llqm_pkg::CMD_GROUP:
                    begin
                        if (stride_reg == '0 || id_oop)
                        begin
                            res_status_next = llqm_pkg::ST_INVALID;
                        end
                        else if (n_reg != '0)
                        begin
                            prod_next  = llqm_pkg::SPAN_W'(n_reg - 1'b1)
                                       * llqm_pkg::SPAN_W'(stride_reg);
                            state_next = S_GRP_CHK;
                        end
                    end
                    llqm_pkg::CMD_POP, llqm_pkg::CMD_PEEK:
                    begin
                        if (ends_disagree)
                        begin
                            res_status_next = llqm_pkg::ST_CORRUPT;
                        end
                        else if (llqm_pkg::is_null(head_reg))
                        begin
                            res_status_next = llqm_pkg::ST_EMPTY;
                        end
                        else if (cmd_reg == llqm_pkg::CMD_POP)
                        begin
                            mem_raddr  = head_reg[llqm_pkg::IDX_W-1:0];
                            state_next = S_POP;
                        end
                        else
                        begin
                            mem_raddr  = tail_reg[llqm_pkg::IDX_W-1:0];
                            state_next = S_PEEK;
                        end
                    end
                    llqm_pkg::CMD_UNLINK, llqm_pkg::CMD_PRESENT:
                    begin
                        if (id_oop)
                        begin
                            res_status_next = llqm_pkg::ST_INVALID;
                        end
                        else
                        begin
                            cur_next   = head_reg;
                            prev_next  = llqm_pkg::PTR_NULL;
                            steps_next = '0;
                            first_next = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                    llqm_pkg::CMD_AUDIT:
                    begin
                        if (ends_disagree)
                        begin
                            res_status_next = llqm_pkg::ST_CORRUPT;
                        end
                        else if (llqm_pkg::is_null(head_reg))
                        begin
                            if (len_reg != '0)
                            begin
                                res_status_next = llqm_pkg::ST_CORRUPT;
                            end
                        end
                        else
                        begin
                            cur_next   = head_reg;
                            prev_next  = llqm_pkg::PTR_NULL;
                            steps_next = '0;
                            first_next = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                        head_next = llqm_pkg::PTR_NULL;
                        tail_next = llqm_pkg::PTR_NULL;
                        len_next  = '0;
                    end
                endcase
            end

            // Second write of a single append: old tail points at the new entry
            S_APPEND2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = tail_reg[llqm_pkg::IDX_W-1:0];
                mem_wdata  = id_ptr;
                tail_next  = id_ptr;
                len_next   = len_reg + 1'b1;
                state_next = S_DONE;
            end

            // Group bounds from the registered product
            S_GRP_CHK:
            begin
                if (llqm_pkg::ROOM_W'(n_reg) > room
                    || span >= llqm_pkg::SPAN_W'(llqm_pkg::ENTRIES))
                begin
                    res_status_next = llqm_pkg::ST_INVALID;
                    state_next      = S_DONE;
                end
                else if (ends_disagree)
                begin
                    res_status_next = llqm_pkg::ST_CORRUPT;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (llqm_pkg::is_null(head_reg))
                    begin
                        head_next = id_ptr;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = tail_reg[llqm_pkg::IDX_W-1:0];
                        mem_wdata = id_ptr;
                    end
                    cur_next   = id_ptr;
                    steps_next = llqm_pkg::ptr_t'(1);
                    state_next = S_GRP_LOOP;
                end
            end

            // One group link per cycle, then terminate the chain
            S_GRP_LOOP:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg[llqm_pkg::IDX_W-1:0];
                if (steps_reg < n_reg)
                begin
                    mem_wdata  = cur_reg + llqm_pkg::PTR_W'(stride_reg);
                    cur_next   = cur_reg + llqm_pkg::PTR_W'(stride_reg);
                    steps_next = steps_reg + 1'b1;
                end
                else
                begin
                    mem_wdata  = llqm_pkg::PTR_NULL;
                    tail_next  = cur_reg;
                    len_next   = len_reg + n_reg;
                    state_next = S_DONE;
                end
            end

            // Pop: successor of the head is in the read register
            S_POP:
            begin
                res_entry_next = head_reg[llqm_pkg::IDX_W-1:0];
                mem_we         = 1'b1;
                mem_waddr      = head_reg[llqm_pkg::IDX_W-1:0];
                mem_wdata      = llqm_pkg::PTR_NULL;
                if (llqm_pkg::is_null(rdata_reg))
                begin
                    head_next = llqm_pkg::PTR_NULL;
                    tail_next = llqm_pkg::PTR_NULL;
                end
                else
                begin
                    head_next = rdata_reg;
                end
                len_next   = len_dec;
                state_next = S_DONE;
            end

            // Peek: the tail must have no successor
            S_PEEK:
            begin
                if (!llqm_pkg::is_null(rdata_reg))
                begin
                    res_status_next = llqm_pkg::ST_CORRUPT;
                end
                else
                begin
                    res_entry_next = tail_reg[llqm_pkg::IDX_W-1:0];
                end
                state_next = S_DONE;
            end

            // List walk, one link per cycle
            S_WALK:
            begin
                first_next = 1'b0;
                mem_raddr  = walk_cur[llqm_pkg::IDX_W-1:0];
                if (llqm_pkg::is_null(walk_cur))
                begin
                    if (cmd_reg == llqm_pkg::CMD_AUDIT)
                    begin
                        res_count_next = steps_reg;
                        if (steps_reg != len_reg)
                        begin
                            res_status_next = llqm_pkg::ST_CORRUPT;
                        end
                    end
                    state_next = S_DONE;
                end
                else if (steps_reg == llqm_pkg::PTR_NULL)
                begin
                    if (cmd_reg == llqm_pkg::CMD_AUDIT)
                    begin
                        res_count_next  = llqm_pkg::PTR_NULL;
                        res_status_next = llqm_pkg::ST_CORRUPT;
                    end
                    state_next = S_DONE;
                end
                else if (cmd_reg != llqm_pkg::CMD_AUDIT && walk_cur == id_ptr)
                begin
                    res_found_next = 1'b1;
                    state_next     = (cmd_reg == llqm_pkg::CMD_UNLINK) ? S_UNLINK : S_DONE;
                end
                else
                begin
                    prev_next  = walk_cur;
                    cur_next   = walk_cur;
                    steps_next = steps_reg + 1'b1;
                end
            end

            // Unlink: successor of the found entry is in the read register
            S_UNLINK:
            begin
                if (!llqm_pkg::is_null(prev_reg))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = prev_reg[llqm_pkg::IDX_W-1:0];
                    if (llqm_pkg::is_null(rdata_reg))
                    begin
                        mem_wdata = llqm_pkg::PTR_NULL;
                        tail_next = prev_reg;
                    end
                    else
                    begin
                        mem_wdata = rdata_reg;
                    end
                    state_next = S_UNL_FIX;
                end
                else
                begin
                    if (llqm_pkg::is_null(rdata_reg))
                    begin
                        head_next = llqm_pkg::PTR_NULL;
                        tail_next = llqm_pkg::PTR_NULL;
                    end
                    else
                    begin
                        head_next = rdata_reg;
                    end
                    mem_we     = 1'b1;
                    mem_waddr  = id_reg;
                    mem_wdata  = llqm_pkg::PTR_NULL;
                    len_next   = len_dec;
                    state_next = S_DONE;
                end
            end

            S_UNL_FIX:
            begin
                mem_we     = 1'b1;
                mem_waddr  = id_reg;
                mem_wdata  = llqm_pkg::PTR_NULL;
                len_next   = len_dec;
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000, count_out, res_found_reg,
                                    res_entry_reg, res_status_reg};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= llqm_pkg::CMD_APPEND;
            id_reg         <= '0;
            n_reg          <= '0;
            stride_reg     <= '0;
            head_reg       <= llqm_pkg::PTR_NULL;
            tail_reg       <= llqm_pkg::PTR_NULL;
            len_reg        <= '0;
            cur_reg        <= llqm_pkg::PTR_NULL;
            prev_reg       <= llqm_pkg::PTR_NULL;
            steps_reg      <= '0;
            first_reg      <= 1'b0;
            prod_reg       <= '0;
            res_status_reg <= llqm_pkg::ST_OK;
            res_entry_reg  <= '0;
            res_found_reg  <= 1'b0;
            res_count_reg  <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            id_reg         <= id_next;
            n_reg          <= n_next;
            stride_reg     <= stride_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            len_reg        <= len_next;
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            steps_reg      <= steps_next;
            first_reg      <= first_next;
            prod_reg       <= prod_next;
            res_status_reg <= res_status_next;
            res_entry_reg  <= res_entry_next;
            res_found_reg  <= res_found_next;
            res_count_reg  <= res_count_next;
            m_valid_reg    <= m_valid_next;
            m_data_reg     <= m_data_next;
        end
    end

    // Checks; a group into an empty list sets the tail only at its last link
    `LLQM_ASSERT_IMP(ends_agree_a, state_reg != S_GRP_LOOP, llqm_pkg::is_null(head_reg) == llqm_pkg::is_null(tail_reg), "head and tail null state differ")
    `LLQM_ASSERT_IMP(len_bound_a, 1'b1, len_reg <= llqm_pkg::PTR_NULL, "length above pool size")
    `LLQM_ASSERT_IMP(walk_bound_a, state_reg == S_WALK, steps_reg <= llqm_pkg::PTR_NULL, "walk beyond pool size")
    `LLQM_ASSERT_NXT(start_a, s_axis_tvalid && s_axis_tready, state_reg == S_EXEC, "accepted command not executed")
    `LLQM_ASSERT_NXT(result_a, state_reg == S_DONE && (!m_valid_reg || m_axis_tready), m_valid_reg && state_reg == S_IDLE, "result not delivered")

endmodule
